// ===== src/rcs_pkg.sv =====
`default_nettype none

package rcs_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int MASK_W      = 16;
  localparam int IDX_W       = 4;
  localparam int AGE_W       = 64;
  localparam int GRP_W       = 3;
  localparam int STAT_W      = 2;

  localparam logic [MASK_W-1:0] DEPTH_MASK =
    (STORE_DEPTH >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((32'd1 << STORE_DEPTH) - 32'd1);

  localparam logic [GRP_W-1:0] GRP_EXP_HIT = 3'd0;
  localparam logic [GRP_W-1:0] GRP_EXP     = 3'd1;
  localparam logic [GRP_W-1:0] GRP_COLL    = 3'd2;
  localparam logic [GRP_W-1:0] GRP_HI_HIT  = 3'd3;
  localparam logic [GRP_W-1:0] GRP_HI      = 3'd4;
  localparam logic [GRP_W-1:0] GRP_LO_HIT  = 3'd5;
  localparam logic [GRP_W-1:0] GRP_LO      = 3'd6;

  localparam logic [STAT_W-1:0] STAT_SELECTED    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE_WAIT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_CLASS   = 2'd2;

endpackage

`default_nettype wire

// ===== src/read_command_selector_unit.sv =====
`default_nettype none
// Read command selector.
// Input channel (in_valid / in_stall): one snapshot of the read command store
// per request: waiting, expired, page-hit, collision and class masks, the
// oldest-first age order, and the low-critical and hit-limit flags.
// Result channel (out_valid / out_stall): the chosen store index, its group and
// a status (selected, nothing waiting, invalid class on a waiting entry).
// Config channel (cfg_valid / cfg_ready): writes prefer_hit_over_high; always
// ready. The user must write it only while idle; the block does not enforce it.
// Two register stages (input register, result register); a request in the input
// register moves on when the result register is empty or its result is taken.
// Throughput: one request per cycle unless a result is stalled; the selection
// and oldest-first age-order scan are one combinational pass between stages.
// Reset (rst_n low, synchronous): both stages empty, register cleared to 0.
// While out_stall holds a pending result, the result register holds; the input
// register still takes one more request, then in_stall rises until the result
// is taken.
module read_command_selector_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [rcs_pkg::MASK_W-1:0]      in_waiting_mask,
  input  wire logic [rcs_pkg::MASK_W-1:0]      in_expired_mask,
  input  wire logic [rcs_pkg::MASK_W-1:0]      in_page_hit_mask,
  input  wire logic [rcs_pkg::MASK_W-1:0]      in_collision_mask,
  input  wire logic [rcs_pkg::MASK_W-1:0]      in_high_class_mask,
  input  wire logic [rcs_pkg::MASK_W-1:0]      in_low_class_mask,
  input  wire logic [rcs_pkg::AGE_W-1:0]       in_age_order,
  input  wire logic                            in_low_critical,
  input  wire logic                            in_hit_limit_reached,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [rcs_pkg::IDX_W-1:0]            out_chosen_index,
  output logic [rcs_pkg::GRP_W-1:0]            out_chosen_group,
  output logic [rcs_pkg::STAT_W-1:0]           out_status,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            cfg_prefer_hit_over_high
);

  logic                           prefer_r;
  logic                           s1_valid_r, s1_valid_nxt;
  logic [rcs_pkg::MASK_W-1:0]     s1_wait_r, s1_exp_r, s1_hit_r, s1_coll_r, s1_hi_r, s1_lo_r;
  logic [rcs_pkg::AGE_W-1:0]      s1_age_r;
  logic                           s1_crit_r, s1_limit_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [rcs_pkg::IDX_W-1:0]      out_index_r;
  logic [rcs_pkg::GRP_W-1:0]      out_group_r;
  logic [rcs_pkg::STAT_W-1:0]     out_status_r;

  logic                           s1_adv;
  logic                           in_acc;

  logic [rcs_pkg::MASK_W-1:0]     wait_m, exp_m, hit_m, coll_m, hi_m, lo_m, eh_m;
  logic [rcs_pkg::MASK_W-1:0]     ord_set [4];
  logic [rcs_pkg::GRP_W-1:0]      ord_grp [4];
  logic [rcs_pkg::MASK_W-1:0]     sel_set;
  logic [rcs_pkg::GRP_W-1:0]      sel_grp;
  logic [rcs_pkg::STAT_W-1:0]     sel_status;
  logic                           cls_bad;

  logic [rcs_pkg::STORE_DEPTH-1:0] age_hv, age_first;
  logic [rcs_pkg::MASK_W-1:0]      low_first;
  logic [rcs_pkg::IDX_W-1:0]       age_idx, low_idx, pick_idx, sel_idx;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_index_r;
  assign out_chosen_group = out_group_r;
  assign out_status       = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefer_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      prefer_r <= cfg_prefer_hit_over_high;
    end
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_wait_r  <= in_waiting_mask;
      s1_exp_r   <= in_expired_mask;
      s1_hit_r   <= in_page_hit_mask;
      s1_coll_r  <= in_collision_mask;
      s1_hi_r    <= in_high_class_mask;
      s1_lo_r    <= in_low_class_mask;
      s1_age_r   <= in_age_order;
      s1_crit_r  <= in_low_critical;
      s1_limit_r <= in_hit_limit_reached;
    end
  end

  always_comb begin
    wait_m  = s1_wait_r & rcs_pkg::DEPTH_MASK;
    exp_m   = s1_exp_r & wait_m;
    hit_m   = s1_hit_r & wait_m;
    coll_m  = s1_coll_r & wait_m;
    hi_m    = s1_hi_r & wait_m;
    lo_m    = s1_lo_r & wait_m;
    eh_m    = s1_limit_r ? '0 : (exp_m & hit_m);
    cls_bad = |(~(hi_m ^ lo_m) & wait_m);

    case ({prefer_r, s1_crit_r})
      2'b00: begin
        ord_set[0] = hi_m & hit_m; ord_grp[0] = rcs_pkg::GRP_HI_HIT;
        ord_set[1] = hi_m;         ord_grp[1] = rcs_pkg::GRP_HI;
        ord_set[2] = lo_m & hit_m; ord_grp[2] = rcs_pkg::GRP_LO_HIT;
        ord_set[3] = lo_m;         ord_grp[3] = rcs_pkg::GRP_LO;
      end
      2'b01: begin
        ord_set[0] = lo_m & hit_m; ord_grp[0] = rcs_pkg::GRP_LO_HIT;
        ord_set[1] = lo_m;         ord_grp[1] = rcs_pkg::GRP_LO;
        ord_set[2] = hi_m & hit_m; ord_grp[2] = rcs_pkg::GRP_HI_HIT;
        ord_set[3] = hi_m;         ord_grp[3] = rcs_pkg::GRP_HI;
      end
      2'b10: begin
        ord_set[0] = hi_m & hit_m; ord_grp[0] = rcs_pkg::GRP_HI_HIT;
        ord_set[1] = lo_m & hit_m; ord_grp[1] = rcs_pkg::GRP_LO_HIT;
        ord_set[2] = hi_m;         ord_grp[2] = rcs_pkg::GRP_HI;
        ord_set[3] = lo_m;         ord_grp[3] = rcs_pkg::GRP_LO;
      end
      default: begin
        ord_set[0] = lo_m & hit_m; ord_grp[0] = rcs_pkg::GRP_LO_HIT;
        ord_set[1] = hi_m & hit_m; ord_grp[1] = rcs_pkg::GRP_HI_HIT;
        ord_set[2] = lo_m;         ord_grp[2] = rcs_pkg::GRP_LO;
        ord_set[3] = hi_m;         ord_grp[3] = rcs_pkg::GRP_HI;
      end
    endcase

    if (exp_m != '0) begin
      if (eh_m != '0) begin
        sel_set = eh_m;  sel_grp = rcs_pkg::GRP_EXP_HIT;
      end else begin
        sel_set = exp_m; sel_grp = rcs_pkg::GRP_EXP;
      end
    end else if (coll_m != '0) begin
      sel_set = coll_m; sel_grp = rcs_pkg::GRP_COLL;
    end else if (ord_set[0] != '0) begin
      sel_set = ord_set[0]; sel_grp = ord_grp[0];
    end else if (ord_set[1] != '0) begin
      sel_set = ord_set[1]; sel_grp = ord_grp[1];
    end else if (ord_set[2] != '0) begin
      sel_set = ord_set[2]; sel_grp = ord_grp[2];
    end else if (ord_set[3] != '0) begin
      sel_set = ord_set[3]; sel_grp = ord_grp[3];
    end else begin
      sel_set = '0; sel_grp = '0;
    end

    if (wait_m == '0) begin
      sel_status = rcs_pkg::STAT_NONE_WAIT;
    end else if (cls_bad) begin
      sel_status = rcs_pkg::STAT_BAD_CLASS;
    end else begin
      sel_status = rcs_pkg::STAT_SELECTED;
    end
  end

  always_comb begin
    for (int k = 0; k < rcs_pkg::STORE_DEPTH; k++) begin
      age_hv[k] = sel_set[s1_age_r[rcs_pkg::IDX_W*k +: rcs_pkg::IDX_W]];
    end
    age_first = age_hv & (~age_hv + rcs_pkg::STORE_DEPTH'(1));
    low_first = sel_set & (~sel_set + rcs_pkg::MASK_W'(1));
    age_idx = '0;
    for (int k = 0; k < rcs_pkg::STORE_DEPTH; k++) begin
      if (age_first[k]) begin
        age_idx = age_idx | s1_age_r[rcs_pkg::IDX_W*k +: rcs_pkg::IDX_W];
      end
    end
    low_idx = '0;
    for (int i = 0; i < rcs_pkg::MASK_W; i++) begin
      if (low_first[i]) begin
        low_idx = low_idx | rcs_pkg::IDX_W'(i);
      end
    end
    pick_idx = (age_hv != '0) ? age_idx : low_idx;
    sel_idx  = (sel_status == rcs_pkg::STAT_SELECTED) ? pick_idx : '0;
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_index_r  <= sel_idx;
      out_group_r  <= (sel_status == rcs_pkg::STAT_SELECTED) ? sel_grp : '0;
      out_status_r <= sel_status;
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != rcs_pkg::STAT_SELECTED)
      |-> (out_index_r == '0) && (out_group_r == '0))
    else $error("error result carries nonzero index or group");

  a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == rcs_pkg::STAT_SELECTED) |-> (out_group_r <= rcs_pkg::GRP_LO))
    else $error("selected result has group out of range");

  a_pick_member: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv && (sel_status == rcs_pkg::STAT_SELECTED) |-> sel_set[sel_idx])
    else $error("chosen index is not in the chosen set");

  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("held request dropped from input stage");

  a_move_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_adv |=> out_valid_r)
    else $error("advancing request did not reach result stage");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/read_selection_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none

module read_selection_checker
  import rcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [MASK_W-1:0]  in_waiting_mask,
  input  wire logic [MASK_W-1:0]  in_expired_mask,
  input  wire logic [MASK_W-1:0]  in_page_hit_mask,
  input  wire logic [MASK_W-1:0]  in_collision_mask,
  input  wire logic [MASK_W-1:0]  in_high_class_mask,
  input  wire logic [MASK_W-1:0]  in_low_class_mask,
  input  wire logic [AGE_W-1:0]   in_age_order,
  input  wire logic               in_low_critical,
  input  wire logic               in_hit_limit_reached,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [IDX_W-1:0]   out_chosen_index,
  input  wire logic [GRP_W-1:0]   out_chosen_group,
  input  wire logic [STAT_W-1:0]  out_status,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic               cfg_prefer_hit_over_high,
  output int                      mismatch_count,
  output int                      choices_pending
);

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [GRP_W-1:0]  group;
    logic [STAT_W-1:0] status;
  } choice_t;

  choice_t expected_choices[$];
  choice_t want;
  logic    prefer_shadow = 1'b0;
  int      new_errors;

  function automatic choice_t select_read_command(
    input logic [MASK_W-1:0] waiting_in,
    input logic [MASK_W-1:0] expired_in,
    input logic [MASK_W-1:0] hit_in,
    input logic [MASK_W-1:0] coll_in,
    input logic [MASK_W-1:0] high_in,
    input logic [MASK_W-1:0] low_in,
    input logic [AGE_W-1:0]  age,
    input logic              critical,
    input logic              limit,
    input logic              prefer
  );
    logic [MASK_W-1:0]            wait_m, exp_m, hit_m, coll_m, hi_m, lo_m, pick_set;
    logic [3:0][MASK_W-1:0]       ranked;
    logic [3:0][GRP_W-1:0]        ranked_grp;
    logic [GRP_W-1:0]             pick_grp;
    logic [IDX_W-1:0]             slot;
    logic                         found;
    choice_t                      c;
    c = '0;
    wait_m = waiting_in & DEPTH_MASK;
    exp_m  = expired_in & wait_m;
    hit_m  = hit_in & wait_m;
    coll_m = coll_in & wait_m;
    hi_m   = high_in & wait_m;
    lo_m   = low_in & wait_m;
    if (wait_m == '0) begin
      c.status = STAT_NONE_WAIT;
      return c;
    end
    if (((hi_m ^ lo_m) & wait_m) != wait_m) begin
      c.status = STAT_BAD_CLASS;
      return c;
    end
    pick_set = '0;
    pick_grp = '0;
    found = 1'b0;
    if (exp_m != '0) begin
      if (!limit && (exp_m & hit_m) != '0) begin
        pick_set = exp_m & hit_m;
        pick_grp = GRP_EXP_HIT;
      end else begin
        pick_set = exp_m;
        pick_grp = GRP_EXP;
      end
    end else if (coll_m != '0) begin
      pick_set = coll_m;
      pick_grp = GRP_COLL;
    end else begin
      case ({prefer, critical})
        2'b00: begin
          ranked     = {hi_m & hit_m, hi_m, lo_m & hit_m, lo_m};
          ranked_grp = {GRP_HI_HIT, GRP_HI, GRP_LO_HIT, GRP_LO};
        end
        2'b01: begin
          ranked     = {lo_m & hit_m, lo_m, hi_m & hit_m, hi_m};
          ranked_grp = {GRP_LO_HIT, GRP_LO, GRP_HI_HIT, GRP_HI};
        end
        2'b10: begin
          ranked     = {hi_m & hit_m, lo_m & hit_m, hi_m, lo_m};
          ranked_grp = {GRP_HI_HIT, GRP_LO_HIT, GRP_HI, GRP_LO};
        end
        default: begin
          ranked     = {lo_m & hit_m, hi_m & hit_m, lo_m, hi_m};
          ranked_grp = {GRP_LO_HIT, GRP_HI_HIT, GRP_LO, GRP_HI};
        end
      endcase
      for (int r = 3; r >= 0; r--) begin
        if (!found && ranked[r] != '0) begin
          pick_set = ranked[r];
          pick_grp = ranked_grp[r];
          found = 1'b1;
        end
      end
    end
    // scan oldest first, fall back to the lowest index
    found = 1'b0;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      slot = age[4*k +: 4];
      if (!found && pick_set[slot]) begin
        c.index = slot;
        found = 1'b1;
      end
    end
    for (int k = 0; k < MASK_W; k++) begin
      if (!found && pick_set[k]) begin
        c.index = IDX_W'(k);
        found = 1'b1;
      end
    end
    c.group  = pick_grp;
    c.status = STAT_SELECTED;
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      prefer_shadow <= 1'b0;
      expected_choices.delete();
      choices_pending <= 0;
      mismatch_count <= 0;
    end else begin
      new_errors = 0;
      if (out_valid && !out_stall) begin
        if (expected_choices.size() == 0) begin
          $error("result with no pending request: index %0d group %0d status %0d",
                 out_chosen_index, out_chosen_group, out_status);
          new_errors++;
        end else begin
          want = expected_choices.pop_front();
          if (out_chosen_index !== want.index) begin
            $error("chosen_index: expected %0d, got %0d", want.index, out_chosen_index);
            new_errors++;
          end
          if (out_chosen_group !== want.group) begin
            $error("chosen_group: expected %0d, got %0d", want.group, out_chosen_group);
            new_errors++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            new_errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_choices.push_back(select_read_command(
          in_waiting_mask, in_expired_mask, in_page_hit_mask, in_collision_mask,
          in_high_class_mask, in_low_class_mask, in_age_order, in_low_critical,
          in_hit_limit_reached, prefer_shadow));
      end
      if (cfg_valid && cfg_ready) begin
        prefer_shadow <= cfg_prefer_hit_over_high;
      end
      mismatch_count <= mismatch_count + new_errors;
      choices_pending <= expected_choices.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/read_command_selector_unit_test.sv =====
`timescale 1ns / 100ps
`default_nettype none

module read_command_selector_unit_test;
  import rcs_pkg::*;

  typedef struct packed {
    logic [MASK_W-1:0] waiting;
    logic [MASK_W-1:0] expired;
    logic [MASK_W-1:0] page_hit;
    logic [MASK_W-1:0] collision;
    logic [MASK_W-1:0] high_class;
    logic [MASK_W-1:0] low_class;
    logic [AGE_W-1:0]  age_order;
    logic              low_critical;
    logic              hit_limit;
  } snapshot_t;

  localparam logic [AGE_W-1:0] AGE_UP   = 64'hFEDC_BA98_7654_3210;
  localparam logic [AGE_W-1:0] AGE_DOWN = 64'h0123_4567_89AB_CDEF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MASK_W-1:0] in_waiting_mask = '0;
  logic [MASK_W-1:0] in_expired_mask = '0;
  logic [MASK_W-1:0] in_page_hit_mask = '0;
  logic [MASK_W-1:0] in_collision_mask = '0;
  logic [MASK_W-1:0] in_high_class_mask = '0;
  logic [MASK_W-1:0] in_low_class_mask = '0;
  logic [AGE_W-1:0]  in_age_order = '0;
  logic              in_low_critical = 1'b0;
  logic              in_hit_limit_reached = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  out_chosen_index;
  logic [GRP_W-1:0]  out_chosen_group;
  logic [STAT_W-1:0] out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_prefer_hit_over_high = 1'b0;

  int mismatch_count;
  int choices_pending;
  int requests_sent = 0;
  int directed_sent = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;

  always #4 clk = ~clk;

  read_command_selector_unit i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_waiting_mask          (in_waiting_mask),
    .in_expired_mask          (in_expired_mask),
    .in_page_hit_mask         (in_page_hit_mask),
    .in_collision_mask        (in_collision_mask),
    .in_high_class_mask       (in_high_class_mask),
    .in_low_class_mask        (in_low_class_mask),
    .in_age_order             (in_age_order),
    .in_low_critical          (in_low_critical),
    .in_hit_limit_reached     (in_hit_limit_reached),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_chosen_index         (out_chosen_index),
    .out_chosen_group         (out_chosen_group),
    .out_status               (out_status),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_prefer_hit_over_high (cfg_prefer_hit_over_high)
  );

  read_selection_checker i_checker (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_waiting_mask          (in_waiting_mask),
    .in_expired_mask          (in_expired_mask),
    .in_page_hit_mask         (in_page_hit_mask),
    .in_collision_mask        (in_collision_mask),
    .in_high_class_mask       (in_high_class_mask),
    .in_low_class_mask        (in_low_class_mask),
    .in_age_order             (in_age_order),
    .in_low_critical          (in_low_critical),
    .in_hit_limit_reached     (in_hit_limit_reached),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_chosen_index         (out_chosen_index),
    .out_chosen_group         (out_chosen_group),
    .out_status               (out_status),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_prefer_hit_over_high (cfg_prefer_hit_over_high),
    .mismatch_count           (mismatch_count),
    .choices_pending          (choices_pending)
  );

  // result side: free flow, light or heavy random stall, periodic stall
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(3);
      mode_left <= $urandom_range(200, 32);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99) < 30);
      2: out_stall <= ($urandom_range(99) < 80);
      default: out_stall <= ((stall_phase % 5) < 3);
    endcase
    stall_phase <= stall_phase + 1;
  end

  function automatic snapshot_t snap(
    input logic [MASK_W-1:0] w, e, h, c, hi, lo,
    input logic [AGE_W-1:0]  age,
    input logic              crit, lim
  );
    return {w, e, h, c, hi, lo, age, crit, lim};
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask(input int pct);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int b = 0; b < MASK_W; b++) begin
      m[b] = ($urandom_range(99) < pct);
    end
    return m;
  endfunction

  task automatic push_request(input snapshot_t s);
    in_valid <= 1'b1;
    in_waiting_mask <= s.waiting;
    in_expired_mask <= s.expired;
    in_page_hit_mask <= s.page_hit;
    in_collision_mask <= s.collision;
    in_high_class_mask <= s.high_class;
    in_low_class_mask <= s.low_class;
    in_age_order <= s.age_order;
    in_low_critical <= s.low_critical;
    in_hit_limit_reached <= s.hit_limit;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // hold input until every pending request has its result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (choices_pending != 0);
  endtask

  task automatic write_prefer(input logic value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_prefer_hit_over_high <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    snapshot_t        s;
    int               burst_left;
    int               gap;
    int               j;
    int               k;
    logic [IDX_W-1:0] perm [16];
    logic [IDX_W-1:0] tmp;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      if ($urandom_range(49) == 0) begin
        drain_results();
      end
      case ($urandom_range(19))
        0: s.waiting = '0;
        1: s.waiting = '1;
        default: s.waiting = rand_mask($urandom_range(90, 5));
      endcase
      s.high_class = MASK_W'($urandom);
      s.low_class = (~s.high_class & s.waiting) | (MASK_W'($urandom) & ~s.waiting);
      if ($urandom_range(19) == 0 && s.waiting != '0) begin
        do j = $urandom_range(15); while (!s.waiting[j]);
        s.high_class[j] = 1'($urandom_range(1));
        s.low_class[j] = s.high_class[j];
      end
      s.expired = MASK_W'($urandom) & ~s.waiting;
      if ($urandom_range(3) == 0) begin
        s.expired |= rand_mask(25) & s.waiting;
      end
      s.collision = MASK_W'($urandom) & ~s.waiting;
      if ($urandom_range(3) == 0) begin
        s.collision |= rand_mask(25) & s.waiting;
      end
      s.page_hit = rand_mask($urandom_range(100));
      if ($urandom_range(9) == 0) begin
        s.age_order = {$urandom, $urandom};
      end else begin
        for (j = 0; j < 16; j++) begin
          perm[j] = IDX_W'(j);
        end
        for (j = 15; j > 0; j--) begin
          k = $urandom_range(j);
          tmp = perm[j];
          perm[j] = perm[k];
          perm[k] = tmp;
        end
        for (j = 0; j < 16; j++) begin
          s.age_order[4*j +: 4] = perm[j];
        end
      end
      s.low_critical = 1'($urandom_range(1));
      s.hit_limit = 1'($urandom_range(1));
      push_request(s);
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    push_request(snap('0, '1, '1, '1, '1, '1, AGE_UP, 1'b1, 1'b1));
    push_request(snap('1, '0, '0, '0, '1, '1, AGE_UP, 1'b0, 1'b0));
    push_request(snap('1, '0, '0, '0, 16'h00FF, 16'hFE00, AGE_UP, 1'b0, 1'b0));
    push_request(snap('1, 16'h0F0F, 16'h00FF, '1, 16'h00FF, 16'hFF00, AGE_DOWN, 1'b0, 1'b0));
    push_request(snap('1, 16'h0F0F, 16'h00FF, '1, 16'h00FF, 16'hFF00, AGE_DOWN, 1'b0, 1'b1));
    push_request(snap('1, '0, '1, 16'h8001, 16'h00FF, 16'hFF00, AGE_UP, 1'b1, 1'b0));
    push_request(snap('1, '0, 16'h0F0F, '0, 16'h00FF, 16'hFF00, AGE_UP, 1'b0, 1'b0));
    push_request(snap('1, '0, 16'h0F0F, '0, 16'h00FF, 16'hFF00, AGE_UP, 1'b1, 1'b0));
    push_request(snap('1, '0, 16'h0F00, '0, 16'h00FF, 16'hFF00, AGE_DOWN, 1'b0, 1'b0));
    push_request(snap('1, '0, 16'h0F00, '0, 16'h00FF, 16'hFF00, AGE_DOWN, 1'b1, 1'b0));
    push_request(snap('1, '0, '0, '0, 16'h00FF, 16'hFF00, AGE_UP, 1'b0, 1'b1));
    push_request(snap('1, '0, '0, '0, 16'h00FF, 16'hFF00, AGE_UP, 1'b1, 1'b1));
    push_request(snap(16'hFF00, '0, '0, '0, '0, 16'hFF00, AGE_DOWN, 1'b0, 1'b0));
    push_request(snap('1, '0, 16'h000F, '0, 16'h00FF, 16'hFF00, AGE_UP, 1'b1, 1'b0));
    push_request(snap(16'h00F0, '0, '0, '0, 16'h00F0, '0, '1, 1'b0, 1'b0));
    push_request(snap(16'h8000, '0, '0, '0, 16'h7FFF, 16'h8000, '0, 1'b1, 1'b1));
    push_request(snap(16'h0001, 16'hFFFE, '1, 16'hFFFE, 16'h0001, 16'hFFFE, AGE_DOWN,
                      1'b1, 1'b0));
    directed_sent = requests_sent;
    write_prefer(1'b1);
    run_random(150);
    write_prefer(1'b0);
    run_random(150);
    write_prefer(1'b1);
    run_random(150);
    write_prefer(1'b0);
    run_random(150);
    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests (%0d directed) across prefer_hit_over_high 0/1/0/1/0,",
             requests_sent, directed_sent);
    $display("with bursty input, random result stall and drained-pipeline pauses.");
    if (mismatch_count == 0 && choices_pending == 0) begin
      $display("read_command_selector_unit regression: pass");
    end else begin
      $display("read_command_selector_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #3_200_000;
    $display("read_command_selector_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
